FILE: rtl/core/biq_pkg.sv
// Shared widths, register index codes and beat types for the biquad section.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package biq_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 24;
  localparam int ACC_W      = 40;
  localparam int ACC_FRAC   = 8;

  // Full product width and the floor shift from Q2.(COEF_W-2) down to the ACC grid
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int PROD_SHIFT = COEF_W - 2 - ACC_FRAC;

  // Configuration port
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // b0 = 1.0 in Q2.22 gives a pass-through filter
  localparam logic [COEF_W-1:0] COEF_B0_RST = COEF_W'(1) << (COEF_W - 2);

  // Input beat: kind 0 filters one sample, kind 1 clears both delays
  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/biquad_iir_df2t_top.sv
// Biquad IIR section, direct form II transposed, top level with sequencer.
// Depends on biq_pkg, biq_mul and biq_sat_add.
//
// One sample beat steps a single multiplier and a single saturating adder
// through the five coefficient products and four sums of the section, and
// a final step hands the result to the output register. That final step
// holds for as long as an earlier result still waits in the output
// register. A clear beat skips the arithmetic and goes to the final step.
// The input is not ready while a beat is in work; the output register lets
// the next beat be taken while a finished result still waits for its
// consumer. A clear beat zeroes both delays and returns sample_out 0 with
// clipped 0. Coefficients are signed Q2.22 and reset to a pass-through filter.
`default_nettype none

module biquad_iir_df2t_top import biq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_beat_t             in_data_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_beat_t            out_data_o
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MB0  = 3'd1;
  localparam logic [2:0] ST_YADD = 3'd2;
  localparam logic [2:0] ST_MA1  = 3'd3;
  localparam logic [2:0] ST_SUB1 = 3'd4;
  localparam logic [2:0] ST_D1   = 3'd5;
  localparam logic [2:0] ST_D2   = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state_q, state_d;

  logic [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [ACC_W-1:0] d1_q, d1_d, d2_q, d2_d;
  logic out_valid_q, out_valid_d;

  // payload registers
  logic                       kind_q, kind_d;
  logic signed [SAMPLE_W-1:0] x_q, x_d;
  logic signed [SAMPLE_W-1:0] y_q, y_d;
  logic                       clip_q, clip_d;
  logic signed [ACC_W-1:0]    p_q, p_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  out_beat_t                  out_q, out_d;

  // shared unit operands and results
  logic signed [COEF_W-1:0]   mul_coef;
  logic signed [SAMPLE_W-1:0] mul_op;
  logic signed [ACC_W-1:0]    mul_term;
  logic signed [ACC_W-1:0]    add_a, add_b, add_sum;
  logic                       add_sub, add_sat;

  // output quantization of the y accumulator
  logic [ACC_W-ACC_FRAC-SAMPLE_W:0] y_top;
  logic                             y_fits;
  logic signed [SAMPLE_W-1:0]       y_sat;

  logic in_acc;
  logic out_free;

  assign in_ready_o  = state_q == ST_IDLE;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Select multiplier operands per step
  always_comb begin
    mul_coef = b0_q;
    mul_op   = x_q;
    case (state_q)
      ST_MB0:  begin mul_coef = b0_q; mul_op = x_q; end
      ST_YADD: begin mul_coef = b1_q; mul_op = x_q; end
      ST_MA1:  begin mul_coef = a1_q; mul_op = y_q; end
      ST_SUB1: begin mul_coef = b2_q; mul_op = x_q; end
      ST_D1:   begin mul_coef = a2_q; mul_op = y_q; end
      default: begin mul_coef = b0_q; mul_op = x_q; end
    endcase
  end

  // Select adder operands per step
  always_comb begin
    add_a   = acc_q;
    add_b   = p_q;
    add_sub = 1'b0;
    case (state_q)
      ST_YADD: begin add_a = p_q;   add_b = d1_q; add_sub = 1'b0; end
      ST_SUB1: begin add_a = acc_q; add_b = p_q;  add_sub = 1'b1; end
      ST_D1:   begin add_a = acc_q; add_b = d2_q; add_sub = 1'b0; end
      ST_D2:   begin add_a = acc_q; add_b = p_q;  add_sub = 1'b1; end
      default: begin add_a = acc_q; add_b = p_q;  add_sub = 1'b0; end
    endcase
  end

  biq_mul u_mul (
    .coef_i    (mul_coef),
    .operand_i (mul_op),
    .term_o    (mul_term)
  );

  biq_sat_add u_add (
    .a_i   (add_a),
    .b_i   (add_b),
    .sub_i (add_sub),
    .sum_o (add_sum),
    .sat_o (add_sat)
  );

  // Floor to an integer and clamp to the sample range
  always_comb begin
    y_top  = add_sum[ACC_W-1:ACC_FRAC+SAMPLE_W-1];
    y_fits = (&y_top) || !(|y_top);
    if (y_fits) begin
      y_sat = add_sum[ACC_FRAC+SAMPLE_W-1:ACC_FRAC];
    end else if (add_sum[ACC_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    kind_d      = kind_q;
    x_d         = x_q;
    y_d         = y_q;
    clip_d      = clip_q;
    p_d         = p_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          kind_d  = in_data_i.kind;
          x_d     = in_data_i.sample_in;
          state_d = ST_MB0;
        end
      end
      ST_MB0: begin
        clip_d = 1'b0;
        if (kind_q) begin
          // clear beat: drop both delays, report zero
          d1_d    = '0;
          d2_d    = '0;
          y_d     = '0;
          state_d = ST_FIN;
        end else begin
          p_d     = mul_term;
          state_d = ST_YADD;
        end
      end
      ST_YADD: begin
        y_d     = y_sat;
        clip_d  = clip_q | add_sat | !y_fits;
        p_d     = mul_term;
        state_d = ST_MA1;
      end
      ST_MA1: begin
        acc_d   = p_q;
        p_d     = mul_term;
        state_d = ST_SUB1;
      end
      ST_SUB1: begin
        acc_d   = add_sum;
        clip_d  = clip_q | add_sat;
        p_d     = mul_term;
        state_d = ST_D1;
      end
      ST_D1: begin
        d1_d    = add_sum;
        clip_d  = clip_q | add_sat;
        acc_d   = p_q;
        p_d     = mul_term;
        state_d = ST_D2;
      end
      ST_D2: begin
        d2_d    = add_sum;
        clip_d  = clip_q | add_sat;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_d.sample_out = y_q;
          out_d.clipped    = clip_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state, delays and coefficients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      b0_q        <= COEF_B0_RST;
      b1_q        <= '0;
      b2_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      d1_q        <= d1_d;
      d2_q        <= d2_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_B0:  b0_q <= cfg_data_i;
          REG_B1:  b1_q <= cfg_data_i;
          REG_B2:  b2_q <= cfg_data_i;
          REG_A1:  a1_q <= cfg_data_i;
          REG_A2:  a2_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    x_q    <= x_d;
    y_q    <= y_d;
    clip_q <= clip_d;
    p_q    <= p_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/biq_mul.sv
// Shared multiplier: coefficient times sample-grid value, floored to the ACC grid.
// Depends on biq_pkg. The caller registers the result.
`default_nettype none

module biq_mul import biq_pkg::*; (
  input  logic signed [COEF_W-1:0]   coef_i,
  input  logic signed [SAMPLE_W-1:0] operand_i,
  output logic signed [ACC_W-1:0]    term_o
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] floored;

  // Full-precision product, then arithmetic shift (floor toward minus infinity)
  assign prod    = coef_i * operand_i;
  assign floored = prod >>> PROD_SHIFT;

  // The floored product always fits the ACC range, so a sign-extending cast suffices
  assign term_o  = ACC_W'(floored);

endmodule

`default_nettype wire

FILE: rtl/core/biq_sat_add.sv
// Shared saturating adder/subtractor on the ACC grid.
// Depends on biq_pkg.
`default_nettype none

module biq_sat_add import biq_pkg::*; (
  input  logic signed [ACC_W-1:0] a_i,
  input  logic signed [ACC_W-1:0] b_i,
  input  logic                    sub_i,
  output logic signed [ACC_W-1:0] sum_o,
  output logic                    sat_o
);

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W:0] wide;

  // One guard bit catches any overflow of a single add or subtract
  always_comb begin
    if (sub_i) begin
      wide = {a_i[ACC_W-1], a_i} - {b_i[ACC_W-1], b_i};
    end else begin
      wide = {a_i[ACC_W-1], a_i} + {b_i[ACC_W-1], b_i};
    end
  end

  // Clamp when the guard bit disagrees with the sign bit
  always_comb begin
    sat_o = wide[ACC_W] != wide[ACC_W-1];
    if (!sat_o) begin
      sum_o = wide[ACC_W-1:0];
    end else if (wide[ACC_W]) begin
      sum_o = ACC_MIN;
    end else begin
      sum_o = ACC_MAX;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/biq_checker.sv
// Port-level checker for the biquad top level, attached by bind below.
// Depends on biq_pkg and biquad_iir_df2t_top.
`default_nettype none

module biq_checker import biq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_o,
  input  in_beat_t             in_data_i,
  input  logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  out_beat_t            out_data_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // The block is busy right after taking a beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again while a beat is in work");

  // A clear beat with a free output returns zero, unclipped
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind && !out_valid_o |->
      ##3 out_valid_o && (out_data_o.sample_out == '0) && !out_data_o.clipped)
    else $error("clear beat gave a wrong or late result");

  // No result appears while the output was idle and nothing was in work
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i && !out_valid_o |=> !out_valid_o)
    else $error("result beat without an input beat");

endmodule

bind biquad_iir_df2t_top biq_checker u_biq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
